@@ rtl/b32n_pkg.sv @@
// ----------------------------------------------------------------------------
// b32n_pkg
// Shared types and constants for the base32 code normalizer.
// ----------------------------------------------------------------------------
package b32n_pkg;

	// Number of symbols in a complete code.
	localparam int CODE_LEN = 8;
	localparam int CountW   = 4;
	localparam int PosW     = 3;
	localparam logic [CountW-1:0] CodeLenC = CountW'(CODE_LEN);

	// Status codes reported with each result.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ILLEGAL  = 2'd1;
	localparam logic [1:0] ST_TOO_MANY = 2'd2;
	localparam logic [1:0] ST_TOO_FEW  = 2'd3;

	// Input item: one character or an end marker.
	typedef struct packed {
		logic [7:0] char_in;
		logic       end_mark;
	} in_item_t;

	// Result item.
	typedef struct packed {
		logic [6:0]      code_char;
		logic [PosW-1:0] position;
		logic            written;
		logic            finished;
		logic            accepted;
		logic [1:0]      status;
	} out_item_t;

	// Classification of one character byte.
	typedef struct packed {
		logic       is_sep;
		logic       is_legal;
		logic [6:0] sym;
	} char_class_t;

endpackage

@@ rtl/b32n_classify.sv @@
// ----------------------------------------------------------------------------
// b32n_classify
// Folds case, applies the look-alike mappings, flags separators and checks the alphabet.
// ----------------------------------------------------------------------------
module b32n_classify import b32n_pkg::*; (
	input  logic [7:0]  char_in,
	output char_class_t cls
);

	logic [7:0] upper;
	logic [7:0] mapped;

	// Fold lower case to upper case.
	always_comb begin
		if (char_in >= 8'h61 && char_in <= 8'h7A) begin
			upper = char_in - 8'h20;
		end else begin
			upper = char_in;
		end
	end

	// O reads as zero, I and L as one, U as V.
	always_comb begin
		case (upper)
			8'h4F:   mapped = 8'h30;
			8'h49:   mapped = 8'h31;
			8'h4C:   mapped = 8'h31;
			8'h55:   mapped = 8'h56;
			default: mapped = upper;
		endcase
	end

	// After the mappings every digit and upper-case letter is in the alphabet.
	always_comb begin
		cls.is_sep   = (char_in == 8'h2D) || (char_in == 8'h20) ||
			(char_in == 8'h5F) || (char_in == 8'h2E);
		cls.is_legal = (mapped >= 8'h30 && mapped <= 8'h39) ||
			(mapped >= 8'h41 && mapped <= 8'h5A);
		cls.sym      = mapped[6:0];
	end

endmodule

@@ rtl/base32_code_normalizer_unit.sv @@
// ----------------------------------------------------------------------------
// base32_code_normalizer_unit
// Normalizes a typed base32 code one character per transfer.
// ----------------------------------------------------------------------------
// Each item is held in the input register and then in the result register,
// from which its result is offered.
// Throughput: one item per cycle unless res_ready stalls; the input register
// and the result register each move on whenever the next stage is free.
// Reset clears the symbol count, the latched error and both valid flags.
// ----------------------------------------------------------------------------
module base32_code_normalizer_unit import b32n_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      char_valid,
	output logic      char_ready,
	input  in_item_t  char_item,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res_item
);

	logic              valid_s1;
	in_item_t          item_s1;
	logic              res_valid_q;
	out_item_t         res_q;
	logic [CountW-1:0] count_q;
	logic [1:0]        err_q;

	logic              out_load;
	char_class_t       cls;
	out_item_t         res_d;
	logic [CountW-1:0] count_d;
	logic [1:0]        err_d;

	// The result register takes a new item when it is empty or being drained.
	assign out_load   = valid_s1 && (!res_valid_q || res_ready);
	assign char_ready = !valid_s1 || out_load;

	b32n_classify u_classify (
		.char_in (item_s1.char_in),
		.cls     (cls)
	);

	// Decide the result and the next state for the item in the input register.
	always_comb begin
		res_d   = '0;
		count_d = count_q;
		err_d   = err_q;
		if (item_s1.end_mark) begin
			res_d.finished = 1'b1;
			if (err_q != ST_OK) begin
				res_d.status = err_q;
			end else if (count_q != CodeLenC) begin
				res_d.status = ST_TOO_FEW;
			end else begin
				res_d.accepted = 1'b1;
			end
			count_d = '0;
			err_d   = ST_OK;
		end else if (err_q != ST_OK) begin
			res_d.status = err_q;
		end else if (cls.is_sep) begin
			res_d.status = ST_OK;
		end else if (!cls.is_legal) begin
			err_d        = ST_ILLEGAL;
			res_d.status = ST_ILLEGAL;
		end else if (count_q >= CodeLenC) begin
			err_d        = ST_TOO_MANY;
			res_d.status = ST_TOO_MANY;
		end else begin
			res_d.code_char = cls.sym;
			res_d.position  = count_q[PosW-1:0];
			res_d.written   = 1'b1;
			count_d         = count_q + CountW'(1);
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			item_s1 <= char_item;
		end
	end

	// Code state and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			err_q       <= ST_OK;
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			count_q     <= count_d;
			err_q       <= err_d;
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule
